// File: src/ps2med_pkg.sv
// Shared types and constants for the PS/2 mouse packet event decoder.
package ps2med_pkg;

	// Framing phase of the incoming byte stream
	localparam logic [1:0] PH_FIRST  = 2'd0;
	localparam logic [1:0] PH_SECOND = 2'd1;
	localparam logic [1:0] PH_THIRD  = 2'd2;

	// Flag byte bit positions
	localparam int FLAG_SYNC   = 3;
	localparam int FLAG_XSIGN  = 4;
	localparam int FLAG_YSIGN  = 5;
	localparam int FLAG_XOVF   = 6;
	localparam int FLAG_YOVF   = 7;

	// Event kinds
	localparam logic [1:0] KIND_BUTTON = 2'd0;
	localparam logic [1:0] KIND_MOTION = 2'd1;
	localparam logic [1:0] KIND_REPORT = 2'd2;

	// Event codes
	localparam logic [1:0] CODE_LEFT   = 2'd0;
	localparam logic [1:0] CODE_RIGHT  = 2'd1;
	localparam logic [1:0] CODE_MIDDLE = 2'd2;
	localparam logic [1:0] CODE_X      = 2'd0;
	localparam logic [1:0] CODE_Y      = 2'd1;
	localparam logic [1:0] CODE_NONE   = 2'd0;

	localparam int VALUE_W = 10;
	localparam int BTN_N   = 3;

	// Pending event bits, lowest goes out first
	localparam int EV_LEFT   = 0;
	localparam int EV_RIGHT  = 1;
	localparam int EV_MIDDLE = 2;
	localparam int EV_X      = 3;
	localparam int EV_Y      = 4;
	localparam int EV_REPORT = 5;
	localparam int EV_N      = 6;

	// Packet queue depth
	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	// One decoded packet handed from front to back
	typedef struct packed {
		logic [BTN_N-1:0]   levels;
		logic [BTN_N-1:0]   changed;
		logic               has_dx;
		logic               has_dy;
		logic [VALUE_W-1:0] dx;
		logic [VALUE_W-1:0] dy_neg;
	} pkt_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

// File: src/ps2med_front.sv
// Front end: frames mouse bytes into packets and classifies them into event sets.
module ps2med_front import ps2med_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] data_byte,
	output logic       push,
	output pkt_t       pkt
);

	logic [1:0]       phase_q;
	logic [7:0]       flags_q;
	logic [7:0]       x_q;
	logic [BTN_N-1:0] buttons_q;

	logic                good_first;
	logic [VALUE_W-1:0]  dy;
	logic [BTN_N-1:0]    changed;

	assign good_first = data_byte[FLAG_SYNC] && !data_byte[FLAG_XOVF] && !data_byte[FLAG_YOVF];

	always_comb begin
		changed     = flags_q[BTN_N-1:0] ^ buttons_q;
		dy          = {{(VALUE_W-8){flags_q[FLAG_YSIGN]}}, data_byte};
		pkt.levels  = flags_q[BTN_N-1:0];
		pkt.changed = changed;
		pkt.dx      = {{(VALUE_W-8){flags_q[FLAG_XSIGN]}}, x_q};
		pkt.dy_neg  = VALUE_W'(0) - dy;
		pkt.has_dx  = (x_q != 8'd0) || flags_q[FLAG_XSIGN];
		pkt.has_dy  = (data_byte != 8'd0) || flags_q[FLAG_YSIGN];
	end

	// Only packets that produce at least one event enter the queue
	assign push = accept && (phase_q == PH_THIRD) &&
		((changed != '0) || pkt.has_dx || pkt.has_dy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_FIRST;
			buttons_q <= '0;
		end else if (accept) begin
			case (phase_q)
				PH_SECOND: begin
					phase_q <= PH_THIRD;
				end
				PH_THIRD: begin
					phase_q   <= PH_FIRST;
					buttons_q <= flags_q[BTN_N-1:0];
				end
				default: begin
					// resync: drop a first byte without the sync bit or with overflow
					phase_q <= good_first ? PH_SECOND : PH_FIRST;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (phase_q == PH_SECOND) x_q <= data_byte;
			if (phase_q != PH_SECOND && phase_q != PH_THIRD && good_first)
				flags_q <= data_byte;
		end
	end

endmodule

// File: src/ps2med_fifo.sv
// Short packet queue between the front end and the event sequencer.
module ps2med_fifo import ps2med_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  pkt_t   wr_pkt,
	input  logic   pop,
	output pkt_t   rd_pkt,
	output qstat_t stat
);

	pkt_t              entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign stat.full  = (count_q == QCNT_W'(QDEPTH));
	assign stat.empty = (count_q == '0);
	assign rd_pkt     = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= wr_pkt;
	end

endmodule

// File: src/ps2med_back.sv
// Back end: steps through the events of one packet and drives the output register.
module ps2med_back import ps2med_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pkt_t                      rd_pkt,
	input  qstat_t                    qstat,
	output logic                      pop,
	input  logic                      out_stall,
	output logic                      out_valid,
	output logic [1:0]                event_kind,
	output logic [1:0]                event_code,
	output logic signed [VALUE_W-1:0] event_value,
	output logic                      last_event
);

	logic [EV_N-1:0]    pend_q;
	logic [BTN_N-1:0]   levels_q;
	logic [VALUE_W-1:0] dx_q;
	logic [VALUE_W-1:0] dy_q;

	logic               valid_q;
	logic [1:0]         kind_q;
	logic [1:0]         code_q;
	logic [VALUE_W-1:0] value_q;
	logic               last_q;

	logic [EV_N-1:0]    sel;
	logic [1:0]         nxt_kind;
	logic [1:0]         nxt_code;
	logic [VALUE_W-1:0] nxt_value;
	logic               advance;
	logic               emit;

	assign pop     = (pend_q == '0) && !qstat.empty;
	assign advance = !valid_q || !out_stall;
	assign emit    = (pend_q != '0) && advance;
	assign sel     = pend_q & (~pend_q + 1'b1);

	always_comb begin
		nxt_kind  = KIND_REPORT;
		nxt_code  = CODE_NONE;
		nxt_value = '0;
		case (sel)
			EV_N'(1) << EV_LEFT: begin
				nxt_kind  = KIND_BUTTON;
				nxt_code  = CODE_LEFT;
				nxt_value = VALUE_W'(levels_q[0]);
			end
			EV_N'(1) << EV_RIGHT: begin
				nxt_kind  = KIND_BUTTON;
				nxt_code  = CODE_RIGHT;
				nxt_value = VALUE_W'(levels_q[1]);
			end
			EV_N'(1) << EV_MIDDLE: begin
				nxt_kind  = KIND_BUTTON;
				nxt_code  = CODE_MIDDLE;
				nxt_value = VALUE_W'(levels_q[2]);
			end
			EV_N'(1) << EV_X: begin
				nxt_kind  = KIND_MOTION;
				nxt_code  = CODE_X;
				nxt_value = dx_q;
			end
			EV_N'(1) << EV_Y: begin
				nxt_kind  = KIND_MOTION;
				nxt_code  = CODE_Y;
				nxt_value = dy_q;
			end
			default: begin
				nxt_kind  = KIND_REPORT;
				nxt_code  = CODE_NONE;
				nxt_value = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				// every queued packet closes with a report
				pend_q <= {1'b1, rd_pkt.has_dy, rd_pkt.has_dx, rd_pkt.changed};
			end else if (emit) begin
				pend_q <= pend_q & ~sel;
			end
			if (emit)         valid_q <= 1'b1;
			else if (advance) valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			levels_q <= rd_pkt.levels;
			dx_q     <= rd_pkt.dx;
			dy_q     <= rd_pkt.dy_neg;
		end
		if (emit) begin
			kind_q  <= nxt_kind;
			code_q  <= nxt_code;
			value_q <= nxt_value;
			last_q  <= ((pend_q & ~sel) == '0);
		end
	end

	assign out_valid   = valid_q;
	assign event_kind  = kind_q;
	assign event_code  = code_q;
	assign event_value = $signed(value_q);
	assign last_event  = last_q;

endmodule

// File: src/ps2_mouse_packet_event_decoder_core.sv
// Top level of the PS/2 mouse packet event decoder.
//
// Input channel (in_valid, in_stall, data_byte) takes one raw mouse byte per word.
// Bytes are framed into three-byte packets; a first byte without bit 3 set or with
// an overflow bit set is dropped. On the third byte the packet yields up to six
// event words: button changes (left, right, middle), X motion, negated Y motion,
// and a closing report; last_event marks the final word of a packet.
// Output channel (out_valid, out_stall, event_*) carries one event word per cycle
// while out_stall is low. The first event of a packet passes through the packet
// queue, the pending-event register and the single output register after its third
// byte is accepted; the output idles between packets while the sequencer loads.
// A byte is accepted every cycle while the two-entry packet queue has room;
// in_stall rises only when that queue is full, which happens when events back up,
// as when the receiver holds out_stall or packets with many events come back to back.
// Reset clears framing to the first byte, all buttons to released, and empties
// the queue and output register. A stalled output word holds until taken.
module ps2_mouse_packet_event_decoder_core import ps2med_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [7:0]                data_byte,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [1:0]                event_kind,
	output logic [1:0]                event_code,
	output logic signed [VALUE_W-1:0] event_value,
	output logic                      last_event
);

	logic   accept;
	logic   push;
	logic   pop;
	pkt_t   wr_pkt;
	pkt_t   rd_pkt;
	qstat_t qstat;

	assign in_stall = qstat.full;
	assign accept   = in_valid && !in_stall;

	ps2med_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.push      (push),
		.pkt       (wr_pkt)
	);

	ps2med_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_pkt (wr_pkt),
		.pop    (pop),
		.rd_pkt (rd_pkt),
		.stat   (qstat)
	);

	ps2med_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd_pkt      (rd_pkt),
		.qstat       (qstat),
		.pop         (pop),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.event_kind  (event_kind),
		.event_code  (event_code),
		.event_value (event_value),
		.last_event  (last_event)
	);

`ifndef SYNTHESIS
	// every packet closes with a report, and only there
	a_last_is_report: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_event == (event_kind == KIND_REPORT)))
		else $error("last_event does not match the report event");

	a_report_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && event_kind == KIND_REPORT) |->
			(event_value == '0 && event_code == CODE_NONE))
		else $error("report event carries a value or code");

	a_button_level: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && event_kind == KIND_BUTTON) |->
			(event_value[VALUE_W-1:1] == '0 && event_code <= CODE_MIDDLE))
		else $error("button event with bad level or code");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.full |-> !push)
		else $error("packet pushed into a full queue");
`endif

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the PS/2 mouse packet event decoder core.
`timescale 1ns / 100ps

module testbench;
	import ps2med_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int PACKET_BYTES = 220;
	localparam int TAIL_CYCLES  = 40;

	typedef struct packed {
		logic [1:0]         kind;
		logic [1:0]         code;
		logic [VALUE_W-1:0] value;
		logic               last;
	} mouse_event_t;

	logic                      clk;
	logic                      arst_n    = 1'b0;
	logic                      in_valid  = 1'b0;
	logic                      in_stall;
	logic [7:0]                data_byte = 8'h00;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [1:0]                event_kind;
	logic [1:0]                event_code;
	logic signed [VALUE_W-1:0] event_value;
	logic                      last_event;

	ps2_mouse_packet_event_decoder_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.event_kind  (event_kind),
		.event_code  (event_code),
		.event_value (event_value),
		.last_event  (last_event)
	);

	// Mouse byte stream waiting to be sent, and the events it should produce
	logic [7:0]   mouse_bytes[$];
	mouse_event_t mouse_events[$];

	// Decoder state as the predictor sees it
	logic [1:0]   frame_phase  = PH_FIRST;
	logic [7:0]   held_flags   = 8'h00;
	logic [7:0]   held_x       = 8'h00;
	logic [2:0]   button_state = 3'b000;

	int error_count = 0;
	int cycle_count = 0;
	int burst_left  = 1;
	int gap_left    = 0;
	int stall_mode  = 0;
	int stall_tick  = 0;
	mouse_event_t want;

	task automatic push_event(input logic [1:0] kind, input logic [1:0] code,
			input logic [VALUE_W-1:0] value, input logic last);
		mouse_event_t ev;
		ev.kind  = kind;
		ev.code  = code;
		ev.value = value;
		ev.last  = last;
		mouse_events.push_back(ev);
	endtask

	// Advance the framing state by one accepted word and queue the events it causes
	task automatic decode_mouse_byte(input logic [7:0] b);
		logic [2:0]         now;
		logic [2:0]         changed;
		logic [VALUE_W-1:0] dx;
		logic [VALUE_W-1:0] dy;
		if (frame_phase == PH_SECOND) begin
			held_x      = b;
			frame_phase = PH_THIRD;
		end else if (frame_phase != PH_THIRD) begin
			frame_phase = PH_FIRST;
			if (b[FLAG_SYNC] && !b[FLAG_XOVF] && !b[FLAG_YOVF]) begin
				held_flags  = b;
				frame_phase = PH_SECOND;
			end
		end else begin
			frame_phase = PH_FIRST;
			now     = held_flags[2:0];
			changed = now ^ button_state;
			dx = {{2{held_flags[FLAG_XSIGN]}}, held_x};
			dy = {{2{held_flags[FLAG_YSIGN]}}, b};
			if (changed[0])
				push_event(KIND_BUTTON, CODE_LEFT, VALUE_W'(now[0]), 1'b0);
			if (changed[1])
				push_event(KIND_BUTTON, CODE_RIGHT, VALUE_W'(now[1]), 1'b0);
			if (changed[2])
				push_event(KIND_BUTTON, CODE_MIDDLE, VALUE_W'(now[2]), 1'b0);
			button_state = now;
			if (dx != '0)
				push_event(KIND_MOTION, CODE_X, dx, 1'b0);
			if (dy != '0)
				push_event(KIND_MOTION, CODE_Y, VALUE_W'(0) - dy, 1'b0);
			// the report always closes a packet that emitted anything
			if (changed != '0 || dx != '0 || dy != '0)
				push_event(KIND_REPORT, CODE_NONE, '0, 1'b1);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("ps2_mouse_packet_event_decoder_core regression: fail");
			$finish;
		end
	end

	// Sender: bursts of words with random gaps; hold the word while stalled
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				decode_mouse_byte(data_byte);
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (mouse_bytes.size() > 0) begin
					in_valid  <= 1'b1;
					data_byte <= mouse_bytes.pop_front();
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 12);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: check each taken word, then pick the next stall
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (mouse_events.size() == 0) begin
					$error("unexpected event word: kind %0d code %0d value %0d last %0b",
						event_kind, event_code, event_value, last_event);
					error_count++;
				end else begin
					want = mouse_events.pop_front();
					if (event_kind !== want.kind) begin
						$error("event_kind: expected %0d, got %0d", want.kind, event_kind);
						error_count++;
					end
					if (event_code !== want.code) begin
						$error("event_code: expected %0d, got %0d", want.code, event_code);
						error_count++;
					end
					if (event_value !== want.value) begin
						$error("event_value: expected %0d, got %0d",
							$signed(want.value), event_value);
						error_count++;
					end
					if (last_event !== want.last) begin
						$error("last_event: expected %0b, got %0b", want.last, last_event);
						error_count++;
					end
				end
			end
			stall_tick++;
			if (stall_tick % 64 == 0)
				stall_mode = $urandom_range(0, 3);
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 9) < 6);
				default: out_stall <= (stall_tick % 16 >= 11);
			endcase
		end
	end

	initial begin : stimulus
		logic [7:0] flags;
		logic [2:0] gen_buttons;
		int         packet_bytes;
		gen_buttons  = 3'b000;
		packet_bytes = 0;

		// rejected first words: no sync bit, one or both overflow bits set
		mouse_bytes.push_back(8'h00);
		mouse_bytes.push_back(8'hF7);
		mouse_bytes.push_back(8'h48);
		mouse_bytes.push_back(8'h88);
		mouse_bytes.push_back(8'hFF);
		// packet with no change and no motion
		mouse_bytes = {mouse_bytes, 8'h08, 8'h00, 8'h00};
		// all buttons pressed, X +255, Y -256 which negates to +256
		mouse_bytes = {mouse_bytes, 8'h2F, 8'hFF, 8'h00};
		// all released, X -256, Y +255
		mouse_bytes = {mouse_bytes, 8'h18, 8'h00, 8'hFF};
		// button changes: left pressed with X +192, then left released with right and middle pressed
		mouse_bytes = {mouse_bytes, 8'h09, 8'hC0, 8'h00};
		mouse_bytes = {mouse_bytes, 8'h0E, 8'h00, 8'h00};
		// negative motion on both axes (X -1, Y -255), middle held
		mouse_bytes = {mouse_bytes, 8'h3C, 8'hFF, 8'h01};

		while (packet_bytes < PACKET_BYTES) begin
			if ($urandom_range(0, 99) < 85) begin
				flags = 8'h08;
				flags[2:0] = ($urandom_range(0, 2) == 0) ? gen_buttons : 3'($urandom);
				flags[FLAG_XSIGN] = 1'($urandom_range(0, 1));
				flags[FLAG_YSIGN] = 1'($urandom_range(0, 1));
				gen_buttons = flags[2:0];
				mouse_bytes.push_back(flags);
				mouse_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
				mouse_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
				packet_bytes += 3;
			end else begin
				// noise: may be dropped or may knock framing off
				repeat ($urandom_range(1, 2))
					mouse_bytes.push_back(8'($urandom));
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (mouse_bytes.size() != 0 || in_valid || mouse_events.size() != 0);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (error_count == 0 && mouse_events.size() == 0)
			$display("ps2_mouse_packet_event_decoder_core regression: pass");
		else
			$display("ps2_mouse_packet_event_decoder_core regression: fail");
		$finish;
	end

endmodule
